@@ sv/aes_pkg.sv @@
// AES package: S-box tables, GF(2^8) helpers, round helpers and controller codes.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int KEY_SCHEDULE_WORDS = 60;
  localparam int KW_AW = $clog2(KEY_SCHEDULE_WORDS);

  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_0    = 3'd1;
  localparam logic [2:0] CFG_KEY_1    = 3'd2;
  localparam logic [2:0] CFG_KEY_2    = 3'd3;
  localparam logic [2:0] CFG_KEY_3    = 3'd4;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  localparam logic REQ_ENC = 1'b0;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // inverse column mix = forward mix of the column pre-multiplied by {04}x^2+{05}
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  // column c, row r is bits [127-32c-8r -: 8]
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) o[127-32*((c+r)%4)-8*r -: 8] = s[127-32*c-8*r -: 8];
        else     o[127-32*c-8*r -: 8] = s[127-32*((c+r)%4)-8*r -: 8];
    return o;
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++)
      o[8*i +: 8] = inv ? inv_sbox(s[8*i +: 8]) : sbox(s[8*i +: 8]);
    return o;
  endfunction

endpackage
`default_nettype wire

@@ sv/aes_block_cipher.sv @@
// AES block cipher top level: key expansion sequencer and iterative round unit.
`timescale 1ns / 1ps
`default_nettype none
// One block per start beat. A key or key-size register write starts a key expansion that writes one
// schedule word per cycle into the round-key memory (Nk loads then 4*(Nr+1)-Nk derived words);
// busy stays high meanwhile, and the same expansion runs after reset.
// A block reads each of its Nr+1 round keys word by word, since the memory hands out one
// 32-bit key word per cycle and a round is applied once its four words are buffered. out_valid
// is registered as the final round is folded in and rises with busy already low, so a new block
// can be taken while out_valid is high. The result shows for one cycle on out_valid and cannot
// be held off.
module aes_block_cipher import aes_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output logic             out_valid,
  output logic [63:0]      out_result_high,
  output logic [63:0]      out_result_low,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEXP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [1:0]   key_size_r;
  logic [63:0]  key_r [4];
  logic [31:0]  rk_mem [KEY_SCHEDULE_WORDS];
  logic [31:0]  w_hist_r [8];       // last eight schedule words, newest at 0
  logic [5:0]   ki_r;               // schedule word index
  logic [2:0]   kmod_r;             // ki mod nk
  logic [7:0]   rcon_r;
  logic [3:0]   round_r;
  logic [1:0]   col_r;
  logic [127:0] st_r;
  logic [95:0]  kbuf_r;
  logic [31:0]  rd_r;
  logic         dec_r;
  logic         first_r;
  logic         out_valid_r;
  logic [3:0]   nr;
  logic [3:0]   nk;
  logic [5:0]   total;
  logic [127:0] rnd_prev;
  logic [127:0] last_fold;

  always_comb begin
    unique case (key_size_r)
      KS_128:  nr = 4'd10;
      KS_192:  nr = 4'd12;
      default: nr = 4'd14;
    endcase
    nk = nr - 4'd6;
    total = 6'({nr, 2'b00} + 6'd4);
  end

  // key expansion word
  logic [31:0] t_w, new_w;
  always_comb begin
    t_w = w_hist_r[0];
    if (kmod_r == 3'd0)
      t_w = sub_word({w_hist_r[0][23:0], w_hist_r[0][31:24]}) ^ {rcon_r, 24'h0};
    else if (nk > 4'd6 && kmod_r == 3'd4)
      t_w = sub_word(w_hist_r[0]);
    new_w = w_hist_r[3'(nk - 4'd1)] ^ t_w;
  end

  logic [31:0] load_w;
  always_comb begin
    load_w = ki_r[0] ? key_r[ki_r[2:1]][31:0] : key_r[ki_r[2:1]][63:32];
  end

  // round sequencing: the round key is read word by word one round ahead into kbuf
  logic [3:0] rd_round;
  logic [5:0] rd_addr;
  always_comb begin
    rd_round = dec_r ? 4'(nr - round_r) : round_r;
    rd_addr = 6'({rd_round, col_r});
  end

  logic start_ok;
  assign start_ok = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start_ok) state_nxt = ST_RUN;
      ST_KEXP: if (ki_r == total - 6'd1) state_nxt = ST_IDLE;
      ST_RUN:  if (round_r == nr + 4'd1) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && cfg_index <= CFG_KEY_3) state_nxt = ST_KEXP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_KEXP;
      key_size_r <= KS_128;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      ki_r <= '0;
      kmod_r <= '0;
      rcon_r <= 8'h01;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_SIZE: key_size_r <= cfg_data[1:0];
          CFG_KEY_0:    key_r[0] <= cfg_data;
          CFG_KEY_1:    key_r[1] <= cfg_data;
          CFG_KEY_2:    key_r[2] <= cfg_data;
          CFG_KEY_3:    key_r[3] <= cfg_data;
          default: ;
        endcase
      end
      if (state_nxt == ST_KEXP && state_r != ST_KEXP || cfg_we) begin
        ki_r <= '0;
        kmod_r <= '0;
        rcon_r <= 8'h01;
      end else if (state_r == ST_KEXP) begin
        ki_r <= ki_r + 6'd1;
        kmod_r <= (kmod_r == 3'(nk - 4'd1)) ? 3'd0 : kmod_r + 3'd1;
        if (ki_r >= 6'(nk) && kmod_r == 3'd0) rcon_r <= xtime(rcon_r);
      end
      if (state_r == ST_RUN && state_nxt == ST_IDLE) out_valid_r <= 1'b1;
    end
  end

  // schedule memory and datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_KEXP) begin
      logic [31:0] w;
      w = (ki_r < 6'(nk)) ? load_w : new_w;
      if (ki_r < 6'(KEY_SCHEDULE_WORDS)) rk_mem[ki_r[KW_AW-1:0]] <= w;
      for (int i = 7; i > 0; i--) w_hist_r[i] <= w_hist_r[i-1];
      w_hist_r[0] <= w;
    end
    rd_r <= rk_mem[rd_addr[KW_AW-1:0]];
    if (start_ok) begin
      dec_r <= in_req_type;
      st_r <= {in_block_high, in_block_low};
      round_r <= 4'd0;
      col_r <= 2'd0;
      first_r <= 1'b1;
    end else if (state_r == ST_RUN) begin
      col_r <= col_r + 2'd1;
      kbuf_r <= {kbuf_r[63:0], rd_r};
      if (col_r == 2'd0 && !first_r) begin
        // kbuf holds the full key of round_r-1 now, with rd_r the last word
        if (round_r == 4'd1) st_r <= st_r ^ {kbuf_r, rd_r};
        else st_r <= rnd_prev;
      end
      if (col_r == 2'd3) begin
        round_r <= round_r + 4'd1;
        first_r <= 1'b0;
      end
    end
  end

  // round step applies with the completed key buffer at column 0 of the next round
  logic [127:0] sr2, sb2, mx2, ark2;
  logic [127:0] kfull;
  logic         last_prev;
  always_comb begin
    kfull = {kbuf_r, rd_r};
    last_prev = (round_r == nr + 4'd1);
    sr2 = shift_rows(st_r, dec_r);
    sb2 = sub_bytes(sr2, dec_r);
    mx2 = sb2;
    ark2 = sb2 ^ kfull;
    rnd_prev = ark2;
    if (!dec_r) begin
      if (!last_prev)
        for (int c = 0; c < 4; c++) mx2[127-32*c -: 32] = mix_col(sb2[127-32*c -: 32]);
      rnd_prev = mx2 ^ kfull;
    end else if (!last_prev) begin
      for (int c = 0; c < 4; c++) rnd_prev[127-32*c -: 32] = inv_mix_col(ark2[127-32*c -: 32]);
    end
    last_fold = ark2;
  end

  // final state: last round folded in and registered together with out_valid
  logic [127:0] fin_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN && state_nxt == ST_IDLE) fin_r <= last_fold;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_result_high = fin_r[127:64];
  assign out_result_low = fin_r[63:0];

endmodule
`default_nettype wire

@@ sv/aes_checker.sv @@
// Port-level checker for the AES block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module aes_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic cfg_we
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_we |=> busy) else $error("busy not raised after start beat");
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat longer than one cycle");
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(cfg_we) |-> !busy) else $error("result shown while busy");
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid) else $error("result right after start");
endmodule

bind aes_block_cipher aes_checker u_aes_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .cfg_we(cfg_we)
);
`default_nettype wire
